// File: hdl/lorq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lorq_pkg
// Shared types and constants for the lossy overwriting ring queue.
// ----------------------------------------------------------------------------
package lorq_pkg;

    localparam int MAX_LOG2_SLOTS = 6;
    localparam int VALUE_WIDTH    = 32;
    localparam int SLOT_COUNT     = 1 << MAX_LOG2_SLOTS;
    localparam int PTR_W          = MAX_LOG2_SLOTS;
    localparam int CAP_W          = 3;

    // item action codes
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef struct packed {
        logic                   action;
        logic [VALUE_WIDTH-1:0] value_in;
    } t_in_item;

    typedef struct packed {
        logic                   value_present;
        logic [VALUE_WIDTH-1:0] value_out;
    } t_out_item;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // latch item, launch slot read
        logic commit;   // write back slot, move pointer, load result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_busy; // result register full and stalled
    } t_sts;

endpackage : lorq_pkg
`default_nettype wire

// File: hdl/lorq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lorq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lorq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : lorq_ram
`default_nettype wire

// File: hdl/lorq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lorq_ctrl
// Sequencer: accept a beat, then commit it once the result register is free.
// ----------------------------------------------------------------------------
module lorq_ctrl
    import lorq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output      logic o_in_stall,
    input  wire t_sts i_sts,
    output      t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_sts.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.commit = !i_sts.out_busy;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    a_accept_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == ST_EXEC)
        else $error("accepted beat not followed by execute");

    a_commit_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && !i_sts.out_busy) |=> r_state == ST_IDLE && !o_in_stall)
        else $error("commit did not return to idle");

    a_busy_holds_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && i_sts.out_busy) |=> r_state == ST_EXEC && o_in_stall)
        else $error("left execute while result register blocked");

endmodule : lorq_ctrl
`default_nettype wire

// File: hdl/lorq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lorq_dp
// Datapath: slot RAM, full bits, ring pointers, capacity register, result reg.
// ----------------------------------------------------------------------------
module lorq_dp
    import lorq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    output      t_sts             o_sts,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_wdata,
    input  wire t_in_item         i_in_data,
    output      logic             o_out_valid,
    output      t_out_item        o_out_data,
    input  wire logic             i_out_stall
);

    logic [CAP_W-1:0]      r_cap;
    logic [PTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [SLOT_COUNT-1:0] r_full,   n_full;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out;
    logic                  r_act;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [PTR_W-1:0]      r_idx;

    logic [CAP_W-1:0]       cap_lg;
    logic [PTR_W-1:0]       ring_mask;
    logic [PTR_W-1:0]       sel_idx;
    logic [PTR_W-1:0]       next_idx;
    logic [VALUE_WIDTH-1:0] ram_rdata;
    logic                   hit;
    logic                   ram_we;

    // clamp log2 capacity to 1..MAX_LOG2_SLOTS
    always_comb begin
        cap_lg = r_cap;
        if (r_cap < CAP_W'(1)) begin
            cap_lg = CAP_W'(1);
        end else if (r_cap > CAP_W'(MAX_LOG2_SLOTS)) begin
            cap_lg = CAP_W'(MAX_LOG2_SLOTS);
        end
    end

    assign ring_mask = ~({PTR_W{1'b1}} << cap_lg);
    assign sel_idx   = (i_in_data.action == ACT_DEQ) ? (r_rd_ptr & ring_mask)
                                                     : (r_wr_ptr & ring_mask);
    assign next_idx  = (r_idx + PTR_W'(1)) & ring_mask;
    assign hit       = r_full[r_idx];
    assign ram_we    = i_cmd.commit && (r_act == ACT_ENQ);

    lorq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_val),
        .i_re    (i_cmd.accept),
        .i_raddr (sel_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_full      = r_full;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.commit) begin
            n_out_valid = 1'b1;
            if (r_act == ACT_ENQ) begin
                n_full[r_idx] = 1'b1;
                n_wr_ptr      = next_idx;
            end else if (hit) begin
                n_full[r_idx] = 1'b0;
                n_rd_ptr      = next_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_W'(MAX_LOG2_SLOTS);
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_full      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_act <= i_in_data.action;
            r_val <= i_in_data.value_in;
            r_idx <= sel_idx;
        end
        if (i_cmd.commit) begin
            r_out.value_present <= hit;
            r_out.value_out     <= hit ? ram_rdata : '0;
        end
    end

    assign o_sts.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

    a_commit_into_free_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !(r_out_valid && i_out_stall))
        else $error("result register overwritten while stalled");

    a_enq_marks_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_act == ACT_ENQ) |=> r_full[$past(r_idx)])
        else $error("enqueued slot not marked full");

    a_empty_deq_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_act == ACT_DEQ && !hit)
            |=> $stable(r_rd_ptr) && $stable(r_full) && !r_out.value_present)
        else $error("dequeue from empty slot changed state");

endmodule : lorq_dp
`default_nettype wire

// File: hdl/lossy_overwrite_ring_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lossy_overwrite_ring_queue_unit
// Lossy ring queue: enqueue overwrites and returns the old payload, dequeue
// takes the slot at the read pointer. Capacity set by one register.
// ----------------------------------------------------------------------------
// Sequence: an accepted beat launches its slot read; write-back and result
//   load follow at commit, which waits while the output register is stalled.
// Input: the next beat is held off until the last one commits; the slot RAM's
//   registered read comes before write-back, and commit waits on output stalls.
// Reset: pointers zero, all full bits cleared at once, capacity 64 slots;
//   no clearing pass, a beat can be taken in the first cycle after reset.
module lossy_overwrite_ring_queue_unit
    import lorq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_wdata,
    input  wire logic             i_in_valid,
    output      logic             o_in_stall,
    input  wire t_in_item         i_in_data,
    output      logic             o_out_valid,
    input  wire logic             i_out_stall,
    output      t_out_item        o_out_data
);

    t_cmd cmd;
    t_sts sts;

    lorq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lorq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule : lossy_overwrite_ring_queue_unit
`default_nettype wire

// File: verif/lorq_ring_checker.sv
// ----------------------------------------------------------------------------
// lorq_ring_checker
// Watches both channels and the capacity register of the lossy ring queue,
// keeps its own copy of slots and pointers, predicts each result on input
// acceptance and compares accepted results in order against the predictions.
// ----------------------------------------------------------------------------
module lorq_ring_checker
    import lorq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_wdata,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_stall,
    input  wire t_in_item         i_in_data,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_stall,
    input  wire t_out_item        i_out_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [VALUE_WIDTH-1:0] slot_data [SLOT_COUNT];
    logic                   slot_held [SLOT_COUNT];
    logic [PTR_W-1:0]       enq_ptr;
    logic [PTR_W-1:0]       deq_ptr;
    logic [CAP_W-1:0]       ring_log2;
    t_out_item              returns_due [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // one enqueue or dequeue against the local ring copy
    function automatic t_out_item ring_step(input t_in_item beat);
        t_out_item        res;
        int               lg;
        logic [PTR_W-1:0] mask;
        logic [PTR_W-1:0] slot;
        lg = int'(ring_log2);
        if (lg < 1) lg = 1;
        if (lg > MAX_LOG2_SLOTS) lg = MAX_LOG2_SLOTS;
        mask = PTR_W'((1 << lg) - 1);
        res  = '0;
        if (beat.action == ACT_ENQ) begin
            slot = enq_ptr & mask;
            if (slot_held[slot]) begin
                res.value_present = 1'b1;
                res.value_out     = slot_data[slot];
            end
            slot_data[slot] = beat.value_in;
            slot_held[slot] = 1'b1;
            enq_ptr         = PTR_W'((slot + 1) & mask);
        end else begin
            slot = deq_ptr & mask;
            if (slot_held[slot]) begin
                res.value_present = 1'b1;
                res.value_out     = slot_data[slot];
                slot_held[slot]   = 1'b0;
                deq_ptr           = PTR_W'((slot + 1) & mask);
            end
        end
        return res;
    endfunction

    function automatic void log_fault(input string what, input t_out_item want,
                                      input t_out_item got);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t: %s: want present=%0b value=%08h, got present=%0b value=%08h",
                     $time, what, want.value_present, want.value_out,
                     got.value_present, got.value_out);
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            foreach (slot_held[i]) begin
                slot_held[i] = 1'b0;
                slot_data[i] = '0;
            end
            enq_ptr   = '0;
            deq_ptr   = '0;
            ring_log2 = CAP_W'(MAX_LOG2_SLOTS);
            returns_due.delete();
        end else begin
            if (i_cfg_we)
                ring_log2 = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                if (returns_due.size() == 0) begin
                    log_fault("result beat with none pending", '0, i_out_data);
                end else begin
                    want = returns_due.pop_front();
                    if (i_out_data.value_present != want.value_present)
                        log_fault("value_present mismatch", want, i_out_data);
                    else if (i_out_data.value_out != want.value_out)
                        log_fault("value_out mismatch", want, i_out_data);
                end
            end
            if (i_in_valid && !i_in_stall)
                returns_due.push_back(ring_step(i_in_data));
        end
        o_pending = returns_due.size();
    end

endmodule : lorq_ring_checker

// File: verif/tb_lossy_overwrite_ring_queue_unit.sv
// ----------------------------------------------------------------------------
// tb_lossy_overwrite_ring_queue_unit
// Drives directed and random enqueue/dequeue traffic through the ring queue
// over a range of capacities, with bursty input and patterned output stalls;
// the checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_lossy_overwrite_ring_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import lorq_pkg::*;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;
    logic             in_valid  = 1'b0;
    t_in_item         in_data   = '0;
    logic             out_stall = 1'b0;
    logic             in_stall;
    logic             out_valid;
    t_out_item        out_data;
    int               fail_count;
    int               pending;

    always #1 clk = ~clk;

    lossy_overwrite_ring_queue_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    lorq_ring_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_in_item make_beat(input logic act, input logic [VALUE_WIDTH-1:0] v);
        t_in_item beat;
        beat.action   = act;
        beat.value_in = v;
        return beat;
    endfunction

    // returns at the edge that took the beat; caller drives again or drops valid
    task automatic send_beat(input t_in_item beat);
        in_valid <= 1'b1;
        in_data  <= beat;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] lg);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= lg;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_random_phase(input int beats, input int enq_pct);
        int   left;
        int   burst;
        int   gap;
        logic act;
        left = beats;
        while (left > 0) begin
            burst = $urandom_range(12, 1);
            if (burst > left) burst = left;
            repeat (burst) begin
                act = ($urandom_range(99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
                send_beat(make_beat(act, $urandom()));
            end
            left -= burst;
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    // output stall: segments of free flow, random, mostly-stalled and long holds
    initial begin : out_stall_gen
        int mode;
        int span;
        int k;
        forever begin
            mode = $urandom_range(3);
            span = $urandom_range(40, 4);
            for (k = 0; k < span; k++) begin
                @(posedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= 1'($urandom_range(1));
                    2: out_stall <= (k % 4) != 3;
                    default: out_stall <= (k < 12);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [CAP_W-1:0] caps [10];
        int               pcts [3];
        int               p;
        caps = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0, 3'd0};
        pcts = '{25, 50, 75};
        caps[8] = CAP_W'($urandom_range(7));
        caps[9] = CAP_W'($urandom_range(7));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-size ring from reset: empty take, extremes, drain past empty
        send_beat(make_beat(ACT_DEQ, 32'h0000_0000));
        send_beat(make_beat(ACT_ENQ, 32'h0000_0000));
        send_beat(make_beat(ACT_ENQ, 32'hFFFF_FFFF));
        send_beat(make_beat(ACT_ENQ, 32'hAAAA_AAAA));
        send_beat(make_beat(ACT_ENQ, 32'h5555_5555));
        send_beat(make_beat(ACT_DEQ, 32'hFFFF_FFFF));
        send_beat(make_beat(ACT_DEQ, 32'h1234_5678));
        send_beat(make_beat(ACT_DEQ, 32'h0000_0000));
        send_beat(make_beat(ACT_DEQ, 32'hFFFF_FFFF));
        send_beat(make_beat(ACT_DEQ, 32'hFFFF_FFFF));

        // two-slot ring with stale pointers: wrap, overwrite, then empty take
        write_capacity(3'd1);
        send_beat(make_beat(ACT_ENQ, 32'h1234_5678));
        send_beat(make_beat(ACT_ENQ, 32'h8765_4321));
        send_beat(make_beat(ACT_ENQ, 32'hDEAD_BEEF));
        send_beat(make_beat(ACT_DEQ, 32'h0000_0000));
        send_beat(make_beat(ACT_DEQ, 32'h0000_0000));
        send_beat(make_beat(ACT_DEQ, 32'h0000_0000));

        // random phases; each capacity change waits for the ring to go quiet
        for (p = 0; p < 10; p++) begin
            write_capacity(caps[p]);
            run_random_phase(100, pcts[$urandom_range(2)]);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule : tb_lossy_overwrite_ring_queue_unit

// File: sim.f
hdl/lorq_pkg.sv
hdl/lorq_ram.sv
hdl/lorq_ctrl.sv
hdl/lorq_dp.sv
hdl/lossy_overwrite_ring_queue_unit.sv
verif/lorq_ring_checker.sv
verif/tb_lossy_overwrite_ring_queue_unit.sv
